@@ rtl/mersenne_twister_prng_top_assert.svh @@
// ----------------------------------------------------------------------------
// mersenne_twister_prng_top_assert.svh
// Assertion macros for the twister generator, clocked on clk_i, reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_PRNG_TOP_ASSERT_SVH
`define MERSENNE_TWISTER_PRNG_TOP_ASSERT_SVH

// property holds outside reset
`define MTP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition never occurs outside reset
`define MTP_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/mtp_pkg.sv @@
// ----------------------------------------------------------------------------
// mtp_pkg
// Types, constants and word functions of the twister generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mtp_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int AW           = $clog2(STATE_WORDS);
  localparam int IDX_W        = $clog2(STATE_WORDS + 2);

  localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
  localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
  localparam logic [31:0] SEED_MULT    = 32'd1664525;
  localparam logic [31:0] DEFAULT_SEED = 32'd5489;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

  typedef enum logic {
    OP_DRAW = 1'b0,
    OP_SEED = 1'b1
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] seed;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_TW_PRE,
    ST_TW_RD,
    ST_TW_WR,
    ST_DRAW_RD,
    ST_DRAW_OUT
  } state_e;

  function automatic logic [31:0] mt_mix(input logic [31:0] upper,
                                         input logic [31:0] lower,
                                         input logic [31:0] far);
    logic [31:0] y;
    logic [31:0] v;
    y = (upper & HIGH_BIT) | (lower & LOW_BITS);
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_MATRIX;
    end
    return v;
  endfunction

  function automatic logic [31:0] mt_temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mtp_ram.sv @@
// ----------------------------------------------------------------------------
// mtp_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mtp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic      [WIDTH-1:0]         rdata0_o,
  output logic      [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

`default_nettype wire

@@ rtl/mtp_fifo.sv @@
// ----------------------------------------------------------------------------
// mtp_fifo
// Small register queue with full/empty flags (DEPTH at least 2).
// ----------------------------------------------------------------------------
`default_nettype none

module mtp_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i & ~full_o;
  assign rd_en   = pop_i & ~empty_o;
  assign data_o  = buf_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/mtp_front.sv @@
// ----------------------------------------------------------------------------
// mtp_front
// Takes input items, turns them into seed/draw commands and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module mtp_front #(
  parameter int DEPTH = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               action_i,
  input  wire logic [31:0]        seed_value_i,
  output logic                    cmd_valid_o,
  output mtp_pkg::cmd_t           cmd_o,
  input  wire logic               cmd_pop_i
);

  import mtp_pkg::*;

  cmd_t in_cmd;
  logic cmd_empty;

  // seed word only matters for a reseed
  always_comb begin
    in_cmd.op   = action_i ? OP_SEED : OP_DRAW;
    in_cmd.seed = action_i ? seed_value_i : '0;
  end

  mtp_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (in_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = ~cmd_empty;

endmodule

`default_nettype wire

@@ rtl/mtp_back.sv @@
// ----------------------------------------------------------------------------
// mtp_back
// Executes commands on the state RAM: seed fill, full twist and tempered draw.
// ----------------------------------------------------------------------------
`default_nettype none

module mtp_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  mtp_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               res_push_o,
  output logic [31:0]        res_word_o,
  input  wire logic          res_full_i
);

  import mtp_pkg::*;

  localparam logic [AW-1:0]    LAST_WORD = AW'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] IDX_TWIST = IDX_W'(STATE_WORDS);
  localparam logic [IDX_W-1:0] IDX_NONE  = IDX_W'(STATE_WORDS + 1);
  localparam logic [AW:0]      OFS_EXT   = (AW + 1)'(TWIST_OFFSET);
  localparam logic [AW:0]      WORDS_EXT = (AW + 1)'(STATE_WORDS);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [AW-1:0]    cnt_q, cnt_d;
  logic [31:0]      word_q, word_d;
  logic [31:0]      cur_q, cur_d;
  logic             after_q, after_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr0, ram_raddr1;
  logic [31:0]      ram_wdata, ram_rdata0, ram_rdata1;
  logic [AW-1:0]    nxt_addr, far_addr;
  logic [AW:0]      far_sum;

  assign nxt_addr = (cnt_q == LAST_WORD) ? '0 : cnt_q + 1'b1;
  assign far_sum  = {1'b0, cnt_q} + OFS_EXT;
  assign far_addr = (far_sum >= WORDS_EXT) ? AW'(far_sum - WORDS_EXT) : far_sum[AW-1:0];

  mtp_ram #(
    .WIDTH (32),
    .DEPTH (STATE_WORDS)
  ) u_state_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr0_i (ram_raddr0),
    .raddr1_i (ram_raddr1),
    .rdata0_o (ram_rdata0),
    .rdata1_o (ram_rdata1)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.op == OP_SEED || idx_q == IDX_NONE) begin
            state_d = ST_SEED;
          end else if (idx_q >= IDX_TWIST) begin
            state_d = ST_TW_PRE;
          end else begin
            state_d = ST_DRAW_RD;
          end
        end
      end
      ST_SEED: begin
        if (cnt_q == LAST_WORD) begin
          state_d = after_q ? ST_TW_PRE : ST_IDLE;
        end
      end
      ST_TW_PRE:  state_d = ST_TW_RD;
      ST_TW_RD:   state_d = ST_TW_WR;
      ST_TW_WR:   state_d = (cnt_q == LAST_WORD) ? ST_DRAW_RD : ST_TW_RD;
      ST_DRAW_RD: state_d = ST_DRAW_OUT;
      ST_DRAW_OUT: begin
        if (!res_full_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_word_o = mt_temper(ram_rdata0);
    ram_we     = 1'b0;
    ram_waddr  = cnt_q;
    ram_wdata  = word_q;
    ram_raddr0 = idx_q[AW-1:0];
    ram_raddr1 = far_addr;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    word_d     = word_q;
    cur_d      = cur_q;
    after_d    = after_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.op == OP_SEED) begin
            word_d  = cmd_i.seed;
            after_d = 1'b0;
          end else begin
            word_d  = DEFAULT_SEED;
            after_d = 1'b1;
          end
        end
      end
      ST_SEED: begin
        ram_we = 1'b1;
        word_d = (word_q * SEED_MULT) + 32'd1;
        if (cnt_q == LAST_WORD) begin
          cnt_d = '0;
          idx_d = IDX_TWIST;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_TW_PRE: begin
        ram_raddr0 = '0;
      end
      ST_TW_RD: begin
        if (cnt_q == '0) begin
          cur_d = ram_rdata0;
        end
        ram_raddr0 = nxt_addr;
        ram_raddr1 = far_addr;
      end
      ST_TW_WR: begin
        ram_we    = 1'b1;
        ram_wdata = mt_mix(cur_q, ram_rdata0, ram_rdata1);
        cur_d     = ram_rdata0;
        if (cnt_q == LAST_WORD) begin
          cnt_d = '0;
          idx_d = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAW_RD: begin
      end
      ST_DRAW_OUT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          idx_d      = idx_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= IDX_NONE;
      cnt_q   <= '0;
      after_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      after_q <= after_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    cur_q  <= cur_d;
  end

endmodule

`default_nettype wire

@@ rtl/mersenne_twister_prng_top.sv @@
// Draw: the dequeued command reads the state RAM (ST_DRAW_RD), then ST_DRAW_OUT queues the tempered
// word once the result queue has room; one state-RAM read. Reseed: fills all 624 state words, one state-RAM write
// per cycle; gives no result. A draw at the end of the state first twists it, with two reads
// and one write on the state RAM per word; an unseeded draw first does the seed fill.
// Reset clears queues and control; the generator starts unseeded.
// ----------------------------------------------------------------------------
// mersenne_twister_prng_top
// 32-bit twister generator: command queue, execution engine, result queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mersenne_twister_prng_top_assert.svh"

module mersenne_twister_prng_top #(
  parameter int CMD_DEPTH = 2,
  parameter int OUT_DEPTH = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        action_i,
  input  wire logic [31:0] seed_value_i,
  output logic             empty,
  input  wire logic        pop,
  output logic      [31:0] random_word_o,
  output logic      [30:0] random_31_o
);

  import mtp_pkg::*;

  cmd_t        cmd;
  logic        cmd_valid;
  logic        cmd_pop;
  logic        res_push;
  logic [31:0] res_word;
  logic        res_full;

  mtp_front #(
    .DEPTH (CMD_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .action_i     (action_i),
    .seed_value_i (seed_value_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  mtp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_word_o  (res_word),
    .res_full_i  (res_full)
  );

  mtp_fifo #(
    .WIDTH (32),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_word),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (random_word_o),
    .empty_o (empty)
  );

  assign random_31_o = random_word_o[31:1];

  `MTP_ASSERT_NEVER(a_push_when_full, res_push && res_full, "result pushed into full queue")
  `MTP_ASSERT_NEVER(a_pop_when_empty, cmd_pop && !cmd_valid, "command taken from empty queue")
  `MTP_ASSERT(a_push_fills, res_push |=> !empty, "queued result not visible")

endmodule

`default_nettype wire
